// ----- rtl/combined_lcg_shuffle_rng_top_assert.svh -----
// assertion macros for the shuffled combined generator
`ifndef COMBINED_LCG_SHUFFLE_RNG_TOP_ASSERT_SVH
`define COMBINED_LCG_SHUFFLE_RNG_TOP_ASSERT_SVH

// same-cycle implication
`define CLSR_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
    else $error("clsr: same-cycle check failed");

// next-cycle implication
`define CLSR_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
    else $error("clsr: next-cycle check failed");

`endif

// ----- rtl/clsr_pkg.sv -----
package clsr_pkg;

  localparam logic [30:0] MOD1        = 31'd2147483563;
  localparam logic [30:0] MOD2        = 31'd2147483399;
  localparam logic [15:0] MUL1        = 16'd40014;
  localparam logic [15:0] MUL2        = 16'd40692;
  localparam logic [15:0] QUO1        = 16'd53668;
  localparam logic [15:0] QUO2        = 16'd52774;
  localparam logic [13:0] REM1        = 14'd12211;
  localparam logic [13:0] REM2        = 14'd3791;
  localparam logic [30:0] SEED2_RESET = 31'd123456789;
  localparam logic [30:0] WRAP_SPAN   = 31'd2147483562;

  // floor(2^32 / quotient) for the reciprocal divide in each lane
  localparam logic [16:0] RECIP1 = 17'((64'd1 << 32) / 64'(QUO1));
  localparam logic [16:0] RECIP2 = 17'((64'd1 << 32) / 64'(QUO2));

  // cycles from a state change until the step results are registered
  localparam int unsigned WAIT_W   = 3;
  localparam logic [2:0]  STEP_LAT = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WARM,
    ST_DRAW
  } state_e;

  typedef struct packed {
    logic load;
    logic commit_warm;
    logic warm_wr;
    logic warm_last;
    logic commit_draw;
  } cmd_t;

  typedef struct packed {
    logic g1_zero;
  } sts_t;

endpackage

// ----- rtl/clsr_ctrl.sv -----
module clsr_ctrl #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  clsr_pkg::sts_t               sts_i,
  output clsr_pkg::cmd_t               cmd_o,
  output logic [$clog2(TABLE_DEPTH)-1:0] wr_addr_o
);
  import clsr_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 8);
  localparam logic [CW-1:0] CNT_START = CW'(TABLE_DEPTH + 7);
  localparam logic [CW-1:0] CNT_DEPTH = CW'(TABLE_DEPTH);

  state_e            state_q, state_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;
  logic              step_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign wr_addr_o   = cnt_q[AW-1:0];

  always_comb begin
    accept      = in_valid_i && (state_q == ST_IDLE);
    out_free    = !out_valid_q || !out_stall_i;
    step_done   = (wait_q == STEP_LAT);
    state_d     = state_q;
    wait_d      = step_done ? wait_q : wait_q + 1'b1;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          wait_d = '0;
          if (restart_i || sts_i.g1_zero) begin
            cmd_o.load = 1'b1;
            cnt_d      = CNT_START;
            state_d    = ST_WARM;
          end else begin
            state_d = ST_DRAW;
          end
        end
      end
      ST_WARM: begin
        if (step_done) begin
          cmd_o.commit_warm = 1'b1;
          cmd_o.warm_wr     = (cnt_q < CNT_DEPTH);
          wait_d            = '0;
          if (cnt_q == '0) begin
            cmd_o.warm_last = 1'b1;
            state_d         = ST_DRAW;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      ST_DRAW: begin
        if (step_done && out_free) begin
          cmd_o.commit_draw = 1'b1;
          out_valid_d       = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/clsr_dp.sv -----
module clsr_dp #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [30:0]                    seed_i,
  input  clsr_pkg::cmd_t                 cmd_i,
  input  logic [$clog2(TABLE_DEPTH)-1:0] wr_addr_i,
  output clsr_pkg::sts_t                 sts_o,
  output logic [30:0]                    deviate_o
);
  import clsr_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam longint unsigned BUCKET_L =
    64'd1 + (64'(WRAP_SPAN) / 64'(TABLE_DEPTH));
  localparam longint unsigned RB_L = (64'd1 << 32) / BUCKET_L;
  localparam int unsigned RBW = $clog2(RB_L + 1);
  localparam int unsigned QW  = RBW;
  localparam int unsigned PBW = 31 + RBW;
  localparam logic [QW:0] IDX_MAX = (QW + 1)'(TABLE_DEPTH - 1);

  logic [30:0] g1_q, g2_q;
  logic [30:0] last_q;
  logic [30:0] dev_q;
  logic [30:0] seed_eff;
  logic [30:0] n_w [2];

  // index pipeline
  logic [PBW-1:0] pb_q;
  logic [QW-1:0]  kb_c, kb_q;
  logic [31:0]    tb_q;
  logic [QW:0]    kc_c;
  logic [AW-1:0]  idx_q;
  logic [30:0]    rd_q;
  logic [30:0]    mem [TABLE_DEPTH];

  logic signed [32:0] y_c;
  logic [30:0]        y;

  for (genvar l = 0; l < 2; l++) begin : g_lane
    localparam logic [15:0] MUL   = (l == 0) ? MUL1 : MUL2;
    localparam logic [15:0] QUO   = (l == 0) ? QUO1 : QUO2;
    localparam logic [13:0] REM   = (l == 0) ? REM1 : REM2;
    localparam logic [30:0] MODV  = (l == 0) ? MOD1 : MOD2;
    localparam logic [16:0] RECIP = (l == 0) ? RECIP1 : RECIP2;

    logic [30:0] x;
    logic [47:0] p_q;
    logic [15:0] k0;
    logic [15:0] k_q, k_c;
    logic [16:0] t_q, t_c;
    logic [31:0] a_q, b_q;
    logic [32:0] r_c;
    logic [30:0] n_q;

    assign x  = (l == 0) ? g1_q : g2_q;
    assign k0 = p_q[47:32];

    always_comb begin
      if (t_q >= 17'(QUO)) begin
        k_c = k_q + 16'd1;
        t_c = t_q - 17'(QUO);
      end else begin
        k_c = k_q;
        t_c = t_q;
      end
      r_c = {1'b0, a_q} - {1'b0, b_q};
      if (r_c[32]) begin
        r_c = r_c + 33'(MODV);
      end
    end

    always_ff @(posedge clk_i) begin
      p_q <= 48'(x) * 48'(RECIP);
      k_q <= k0;
      t_q <= 17'(32'(x) - 32'(k0) * 32'(QUO));
      a_q <= 32'(MUL) * 32'(t_c[15:0]);
      b_q <= 32'(k_c) * 32'(REM);
      n_q <= r_c[30:0];
    end

    assign n_w[l] = n_q;
  end

  assign seed_eff = (seed_i == 31'd0) ? 31'd1 : seed_i;
  assign kb_c     = QW'(pb_q >> 32);

  always_comb begin
    kc_c = (tb_q >= 32'(BUCKET_L)) ? ({1'b0, kb_q} + 1'b1) : {1'b0, kb_q};
    if (kc_c > IDX_MAX) begin
      kc_c = IDX_MAX;
    end
    y_c = $signed({2'b00, rd_q}) - $signed({2'b00, n_w[1]});
    if (y_c < 33'sd1) begin
      y_c = y_c + $signed({2'b00, WRAP_SPAN});
    end
    if (y_c < 33'sd0) begin
      y_c = '0;
    end
    y = y_c[30:0];
  end

  always_ff @(posedge clk_i) begin
    pb_q  <= PBW'(last_q) * PBW'(RB_L);
    kb_q  <= kb_c;
    tb_q  <= 32'(last_q) - 32'(64'(kb_c) * BUCKET_L);
    idx_q <= kc_c[AW-1:0];
    rd_q  <= mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_warm && cmd_i.warm_wr) begin
      mem[wr_addr_i] <= n_w[0];
    end else if (cmd_i.commit_draw) begin
      mem[idx_q] <= n_w[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit_draw) begin
      dev_q <= y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_q   <= '0;
      g2_q   <= SEED2_RESET;
      last_q <= '0;
    end else if (cmd_i.load) begin
      g1_q <= seed_eff;
      g2_q <= seed_eff;
    end else if (cmd_i.commit_warm) begin
      g1_q <= n_w[0];
      if (cmd_i.warm_last) begin
        last_q <= n_w[0];
      end
    end else if (cmd_i.commit_draw) begin
      g1_q   <= n_w[0];
      g2_q   <= n_w[1];
      last_q <= y;
    end
  end

  assign sts_o.g1_zero = (g1_q == 31'd0);
  assign deviate_o     = dev_q;

endmodule

// ----- rtl/combined_lcg_shuffle_rng_top.sv -----
// Combined two-generator multiplicative congruential source with a shuffle table. Each
// accepted request gives one deviate in 1..2147483562; the uniform fraction is
// deviate / 2147483563. Both generators advance through a four-stage Schrage pipeline
// (reciprocal divide, correction, constant multiplies, modulus fold) that also looks up
// the shuffle slot, so an ordinary draw is one pass through the pipeline; its result is
// registered when the pass ends and the output register is free. A request with restart
// set, or the first one after reset, reseeds first and runs TABLE_DEPTH+8 warm-up steps,
// each one pass through the pipeline. Input is stalled while a request is in flight; a
// finished result waits in an output register while the next request is taken.
module combined_lcg_shuffle_rng_top #(
  parameter int unsigned TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        restart_i,
  input  logic [30:0] seed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] deviate_o
);
  import clsr_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] wr_addr;

  clsr_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .restart_i  (restart_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr)
  );

  clsr_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_i    (seed_i),
    .cmd_i     (cmd),
    .wr_addr_i (wr_addr),
    .sts_o     (sts),
    .deviate_o (deviate_o)
  );

endmodule

// ----- rtl/clsr_checker.sv -----
`include "combined_lcg_shuffle_rng_top_assert.svh"

module clsr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        restart_i,
  input logic [30:0] seed_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [30:0] deviate_o
);
  import clsr_pkg::*;

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // one request in flight at a time
  `CLSR_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_acc, in_stall_o)

  // no result can appear straight after a request is taken
  `CLSR_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_acc, !$rose(out_valid_o))

  // deviate stays inside the wrapped range
  `CLSR_ASSERT_IMPL(a_range, clk_i, rst_ni, out_valid_o, (deviate_o != 31'd0) && (deviate_o <= WRAP_SPAN))

  // held result stays put
  `CLSR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(deviate_o))

endmodule

bind combined_lcg_shuffle_rng_top clsr_checker u_clsr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .restart_i  (restart_i),
  .seed_i     (seed_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .deviate_o  (deviate_o)
);
